// ===== sv/gpsbcd_pkg.sv =====
// gpsbcd_pkg: shared types, constants and helpers of the gps location bcd encoder
`default_nettype none

package gpsbcd_pkg;

	// pipeline depth: input stage s1 through output register s10
	localparam int NSTAGE = 10;

	typedef logic [NSTAGE:1] stage_vec_t;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SATS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GPS_ON   = 1'd1;
	localparam logic [5:0] MIN_SATS_RST = 6'd4;
	localparam logic       GPS_ON_RST   = 1'b1;

	// status flag bits
	localparam logic [7:0] FLAG_NORTH       = 8'h01;
	localparam logic [7:0] FLAG_EAST        = 8'h02;
	localparam logic [7:0] FLAG_LON_OVER_99 = 8'h04;
	localparam logic [7:0] FLAG_FIX         = 8'h08;
	localparam logic [7:0] FLAG_DATA        = 8'h10;
	localparam logic [7:0] FLAG_3D          = 8'h20;
	localparam logic [7:0] FLAG_NEG_ALT     = 8'h80;

	// decimal constants
	localparam logic [31:0] DEG_UNITS = 32'd10000000;
	localparam logic [16:0] HUNDRED_K = 17'd100000;
	localparam logic [9:0]  THOUSAND  = 10'd1000;
	localparam logic [6:0]  HUNDRED   = 7'd100;
	localparam logic [5:0]  SIXTY     = 6'd60;
	localparam logic [6:0]  HDOP_MAX  = 7'd99;
	localparam logic [6:0]  DEG_LIMIT = 7'd99;

	// reciprocals for constant division: floor(x*m >> k) == floor(x/d) over the input range
	// (x>>7)/78125, x < 2^25, k = 42
	localparam logic [25:0] DEG_RECIP   = 26'd56294996;
	// (x>>7)/78125, x < 2^23, k = 40
	localparam logic [23:0] MIN_RECIP   = 24'd14073749;
	// (x>>5)/3125, x < 2^19, k = 31
	localparam logic [19:0] FRAC_RECIP  = 20'd687195;
	// (x>>3)/125, x < 2^14, k = 21
	localparam logic [14:0] MILLI_RECIP = 15'd16778;
	// x/100, x < 2^9, k = 16
	localparam logic [9:0]  DEG_H_RECIP = 10'd656;
	// (x>>5)/3125, x < 2^23, k = 35
	localparam logic [23:0] ALT_RECIP   = 24'd10995117;
	// x/100, x < 2^12, k = 19
	localparam logic [12:0] CRS_RECIP   = 13'd5243;
	// x/10, x < 2^16, k = 20
	localparam logic [16:0] HDOP_RECIP  = 17'd104858;
	// x/10, x < 2^10, k = 14
	localparam logic [10:0] TENTH_RECIP = 11'd1639;

	// side data entering the altitude/course/hdop path
	typedef struct packed {
		logic [27:0] alt_mag;
		logic [11:0] course;
		logic [15:0] hdop;
		logic        north;
		logic        east;
		logic        alt_neg;
	} aux_in_t;

	// binary digit pairs from the altitude/course/hdop path
	typedef struct packed {
		logic [6:0] alt_hi;
		logic [6:0] alt_lo;
		logic [5:0] crs_hi;
		logic [6:0] crs_lo;
		logic [6:0] hdop;
		logic       north;
		logic       east;
		logic       alt_neg;
	} aux_res_t;

	// binary digit pairs of one coordinate
	typedef struct packed {
		logic       over99;
		logic [6:0] deg_lo;
		logic [6:0] minutes;
		logic [6:0] frac_hi;
		logic [6:0] frac_lo;
	} coord_res_t;

	// two bcd digits of a value below 100 (shift and add-3)
	function automatic logic [7:0] bcd2(input logic [6:0] bin);
		logic [14:0] sr;
		sr = {8'd0, bin};
		for (int i = 0; i < 7; i++) begin
			if (sr[10:7] >= 4'd5) begin
				sr[10:7] = sr[10:7] + 4'd3;
			end
			if (sr[14:11] >= 4'd5) begin
				sr[14:11] = sr[14:11] + 4'd3;
			end
			sr = {sr[13:0], 1'b0};
		end
		return sr[14:7];
	endfunction

endpackage

`default_nettype wire

// ===== sv/gpsbcd_ifs.sv =====
// gpsbcd interfaces: gps solution channel and location record channel
`default_nettype none

interface gpsbcd_sol_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic signed [27:0] altitude_cm;
	logic [11:0]        course_decideg;
	logic [15:0]        hdop_centi;
	logic [5:0]         satellite_count;
	logic               fix_valid;

	modport source (
		output valid, latitude, longitude, altitude_cm, course_decideg, hdop_centi,
			satellite_count, fix_valid,
		input ready
	);
	modport sink (
		input valid, latitude, longitude, altitude_cm, course_decideg, hdop_centi,
			satellite_count, fix_valid,
		output ready
	);
endinterface

interface gpsbcd_rec_if;
	logic        valid;
	logic        ready;
	logic [15:0] altitude_low_bcd;
	logic [31:0] latitude_bcd;
	logic [31:0] longitude_bcd;
	logic [15:0] course_bcd;
	logic [7:0]  hdop_bcd;
	logic [7:0]  status_flags;

	modport source (
		output valid, altitude_low_bcd, latitude_bcd, longitude_bcd, course_bcd, hdop_bcd,
			status_flags,
		input ready
	);
	modport sink (
		input valid, altitude_low_bcd, latitude_bcd, longitude_bcd, course_bcd, hdop_bcd,
			status_flags,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/gpsbcd_coord.sv =====
// gpsbcd_coord: coordinate magnitude to degree, minute and fractional minute digit pairs
`default_nettype none

module gpsbcd_coord (
	input  logic                   clk,
	input  gpsbcd_pkg::stage_vec_t stage_en,
	input  logic [31:0]            mag_s1,
	output gpsbcd_pkg::coord_res_t res_s9
);

	logic [31:0] mag_s2;
	logic [8:0]  deg_s2;
	logic [8:0]  deg_s3;
	logic [23:0] rem_s3;
	logic [2:0]  degh_s3;
	logic [29:0] rem60_s4;
	logic [29:0] rem60_s5;
	logic [23:0] r2_s6;
	logic [23:0] r2_s7;
	logic [16:0] fr2_s8;
	gpsbcd_pkg::coord_res_t res_s4, res_s5, res_s6, res_s7, res_s8;

	logic [50:0] deg_prod;
	logic [31:0] rem_d;
	logic [18:0] degh_prod;
	logic [29:0] rem60_d;
	logic [8:0]  deg_lo_d;
	logic [46:0] min_prod;
	logic [29:0] r2_d;
	logic [38:0] fh_prod;
	logic [23:0] fr2_d;
	logic [28:0] fl_prod;
	gpsbcd_pkg::coord_res_t res4_d, res5_d, res7_d, res9_d;

	// per-stage arithmetic: reciprocal multiplies and multiply-subtracts, up to two per stage
	always_comb begin
		deg_prod  = 51'(mag_s1[31:7]) * 51'(gpsbcd_pkg::DEG_RECIP);
		rem_d     = mag_s2 - 32'(deg_s2) * gpsbcd_pkg::DEG_UNITS;
		degh_prod = 19'(deg_s2) * 19'(gpsbcd_pkg::DEG_H_RECIP);
		rem60_d   = 30'(rem_s3) * 30'(gpsbcd_pkg::SIXTY);
		deg_lo_d  = deg_s3 - 9'(degh_s3) * 9'(gpsbcd_pkg::HUNDRED);
		min_prod  = 47'(rem60_s4[29:7]) * 47'(gpsbcd_pkg::MIN_RECIP);
		r2_d      = rem60_s5 - 30'(res_s5.minutes) * 30'(gpsbcd_pkg::DEG_UNITS);
		fh_prod   = 39'(r2_s6[23:5]) * 39'(gpsbcd_pkg::FRAC_RECIP);
		fr2_d     = r2_s7 - 24'(res_s7.frac_hi) * 24'(gpsbcd_pkg::HUNDRED_K);
		fl_prod   = 29'(fr2_s8[16:3]) * 29'(gpsbcd_pkg::MILLI_RECIP);

		res4_d         = '0;
		res4_d.over99  = (deg_s3 > 9'(gpsbcd_pkg::DEG_LIMIT));
		res4_d.deg_lo  = deg_lo_d[6:0];
		res5_d         = res_s4;
		res5_d.minutes = min_prod[46:40];
		res7_d         = res_s6;
		res7_d.frac_hi = fh_prod[37:31];
		res9_d         = res_s8;
		res9_d.frac_lo = fl_prod[27:21];
	end

	// pipeline registers, each stage loads on its own enable
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			mag_s2 <= mag_s1;
			deg_s2 <= deg_prod[50:42];
		end
		if (stage_en[3]) begin
			deg_s3  <= deg_s2;
			rem_s3  <= rem_d[23:0];
			degh_s3 <= degh_prod[18:16];
		end
		if (stage_en[4]) begin
			rem60_s4 <= rem60_d;
			res_s4   <= res4_d;
		end
		if (stage_en[5]) begin
			rem60_s5 <= rem60_s4;
			res_s5   <= res5_d;
		end
		if (stage_en[6]) begin
			r2_s6  <= r2_d[23:0];
			res_s6 <= res_s5;
		end
		if (stage_en[7]) begin
			r2_s7  <= r2_s6;
			res_s7 <= res7_d;
		end
		if (stage_en[8]) begin
			fr2_s8 <= fr2_d[16:0];
			res_s8 <= res_s7;
		end
		if (stage_en[9]) begin
			res_s9 <= res9_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/gpsbcd_aux.sv =====
// gpsbcd_aux: altitude, course and hdop digit pairs plus side flags
`default_nettype none

module gpsbcd_aux (
	input  logic                   clk,
	input  gpsbcd_pkg::stage_vec_t stage_en,
	input  gpsbcd_pkg::aux_in_t    in_s1,
	output gpsbcd_pkg::aux_res_t   res_s9
);

	logic [27:0] alt_s2;
	logic [11:0] altq_s2;
	logic [11:0] crs_s2;
	logic [5:0]  crsq_s2;
	logic [12:0] hdq_s2;
	logic [16:0] ar_s3;
	logic [16:0] ar_s4;
	logic [9:0]  arl_s5;
	gpsbcd_pkg::aux_res_t res_s2, res_s3, res_s4, res_s5, res_s6, res_s7, res_s8;

	logic [46:0] alt_prod;
	logic [24:0] crs_prod;
	logic [32:0] hd_prod;
	logic [27:0] ar_d;
	logic [11:0] crs_lo_d;
	logic [28:0] ah_prod;
	logic [16:0] arl_d;
	logic [20:0] al_prod;
	gpsbcd_pkg::aux_res_t res2_d, res3_d, res4_d, res6_d;

	// per-stage arithmetic
	always_comb begin
		alt_prod = 47'(in_s1.alt_mag[27:5]) * 47'(gpsbcd_pkg::ALT_RECIP);
		crs_prod = 25'(in_s1.course) * 25'(gpsbcd_pkg::CRS_RECIP);
		hd_prod  = 33'(in_s1.hdop) * 33'(gpsbcd_pkg::HDOP_RECIP);
		ar_d     = alt_s2 - 28'(altq_s2) * 28'(gpsbcd_pkg::HUNDRED_K);
		crs_lo_d = crs_s2 - 12'(crsq_s2) * 12'(gpsbcd_pkg::HUNDRED);
		ah_prod  = 29'(ar_s3[16:3]) * 29'(gpsbcd_pkg::MILLI_RECIP);
		arl_d    = ar_s4 - 17'(res_s4.alt_hi) * 17'(gpsbcd_pkg::THOUSAND);
		al_prod  = 21'(arl_s5) * 21'(gpsbcd_pkg::TENTH_RECIP);

		res2_d         = '0;
		res2_d.north   = in_s1.north;
		res2_d.east    = in_s1.east;
		res2_d.alt_neg = in_s1.alt_neg;

		// course split and hdop saturation
		res3_d        = res_s2;
		res3_d.crs_hi = crsq_s2;
		res3_d.crs_lo = crs_lo_d[6:0];
		res3_d.hdop   = (hdq_s2 > 13'(gpsbcd_pkg::HDOP_MAX)) ? gpsbcd_pkg::HDOP_MAX
			: hdq_s2[6:0];

		res4_d        = res_s3;
		res4_d.alt_hi = ah_prod[27:21];
		res6_d        = res_s5;
		res6_d.alt_lo = al_prod[20:14];
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			alt_s2  <= in_s1.alt_mag;
			altq_s2 <= alt_prod[46:35];
			crs_s2  <= in_s1.course;
			crsq_s2 <= crs_prod[24:19];
			hdq_s2  <= hd_prod[32:20];
			res_s2  <= res2_d;
		end
		if (stage_en[3]) begin
			ar_s3  <= ar_d[16:0];
			res_s3 <= res3_d;
		end
		if (stage_en[4]) begin
			ar_s4  <= ar_s3;
			res_s4 <= res4_d;
		end
		if (stage_en[5]) begin
			arl_s5 <= arl_d[9:0];
			res_s5 <= res_s4;
		end
		if (stage_en[6]) begin
			res_s6 <= res6_d;
		end
		if (stage_en[7]) begin
			res_s7 <= res_s6;
		end
		if (stage_en[8]) begin
			res_s8 <= res_s7;
		end
		if (stage_en[9]) begin
			res_s9 <= res_s8;
		end
	end

endmodule

`default_nettype wire

// ===== sv/gps_location_bcd_encoder.sv =====
// gps_location_bcd_encoder: gps solution to bcd telemetry location record, top level
//
//  channel    | dir | handshake     | content
//  -----------+-----+---------------+-------------------------------------------
//  solution   | in  | valid / ready | lat, lon, altitude, course, hdop, sats, fix
//  record     | out | valid / ready | bcd location record and status flags
//  cfg_*      | in  | write enable  | min_satellites (index 0), gps_feature_on (1)
//
// Ten register stages, one solution per cycle while solution.ready is high;
// record.valid rises when the solution reaches s10. Depth is set by the coordinate
// path, a chain of four reciprocal multiplies separated by multiply-subtract stages.
// Reset clears the stage valid bits and loads the configuration defaults.
// Each stage has its own valid bit, so bubbles close up under a stall and
// solution.ready stays high while any stage is free.
`default_nettype none

module gps_location_bcd_encoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gpsbcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpsbcd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	gpsbcd_sol_if.sink                          solution,
	gpsbcd_rec_if.source                        record
);

	logic [5:0] min_sats_q;
	logic       gps_on_q;

	gpsbcd_pkg::stage_vec_t stage_en;
	gpsbcd_pkg::stage_vec_t vld_q;

	logic [31:0]          lat_mag_s1;
	logic [31:0]          lon_mag_s1;
	gpsbcd_pkg::aux_in_t  aux_s1;

	gpsbcd_pkg::coord_res_t lat_res_s9;
	gpsbcd_pkg::coord_res_t lon_res_s9;
	gpsbcd_pkg::aux_res_t   aux_res_s9;

	logic [15:0] alt_bcd_s10;
	logic [31:0] lat_bcd_s10;
	logic [31:0] lon_bcd_s10;
	logic [15:0] crs_bcd_s10;
	logic [7:0]  hdop_bcd_s10;
	logic [7:0]  flags_s10;

	logic        gate_open;
	logic        lat_neg;
	logic        lon_neg;
	logic        alt_neg;
	logic [30:0] lat_abs;
	logic [31:0] lon_abs;
	logic [27:0] alt_abs;
	gpsbcd_pkg::aux_in_t aux_d;
	logic [7:0]  flags_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sats_q <= gpsbcd_pkg::MIN_SATS_RST;
			gps_on_q   <= gpsbcd_pkg::GPS_ON_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpsbcd_pkg::REG_MIN_SATS: min_sats_q <= cfg_wdata;
				gpsbcd_pkg::REG_GPS_ON:   gps_on_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when it is empty or the next one moves
	always_comb begin
		stage_en[gpsbcd_pkg::NSTAGE] = !vld_q[gpsbcd_pkg::NSTAGE] || record.ready;
		for (int k = gpsbcd_pkg::NSTAGE - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	assign solution.ready = stage_en[1];

	// record gate and magnitudes of the signed fields
	always_comb begin
		gate_open = gps_on_q && solution.fix_valid && (solution.satellite_count >= min_sats_q);
		lat_neg   = solution.latitude[30];
		lon_neg   = solution.longitude[31];
		alt_neg   = solution.altitude_cm[27];
		lat_abs   = lat_neg ? (~solution.latitude + 31'd1) : solution.latitude;
		lon_abs   = lon_neg ? (~solution.longitude + 32'd1) : solution.longitude;
		alt_abs   = alt_neg ? (~solution.altitude_cm + 28'd1) : solution.altitude_cm;

		aux_d.alt_mag = alt_abs;
		aux_d.course  = solution.course_decideg;
		aux_d.hdop    = solution.hdop_centi;
		aux_d.north   = !lat_neg && (solution.latitude != '0);
		aux_d.east    = !lon_neg && (solution.longitude != '0);
		aux_d.alt_neg = alt_neg;
	end

	// valid bits travel with the data; gated transactions enter as bubbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				vld_q[1] <= solution.valid && gate_open;
			end
			for (int k = 2; k <= gpsbcd_pkg::NSTAGE; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// input stage
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			lat_mag_s1 <= {1'b0, lat_abs};
			lon_mag_s1 <= lon_abs;
			aux_s1     <= aux_d;
		end
	end

	gpsbcd_coord u_lat (
		.clk      (clk),
		.stage_en (stage_en),
		.mag_s1   (lat_mag_s1),
		.res_s9   (lat_res_s9)
	);

	gpsbcd_coord u_lon (
		.clk      (clk),
		.stage_en (stage_en),
		.mag_s1   (lon_mag_s1),
		.res_s9   (lon_res_s9)
	);

	gpsbcd_aux u_aux (
		.clk      (clk),
		.stage_en (stage_en),
		.in_s1    (aux_s1),
		.res_s9   (aux_res_s9)
	);

	// status flags
	always_comb begin
		flags_d = gpsbcd_pkg::FLAG_FIX | gpsbcd_pkg::FLAG_DATA | gpsbcd_pkg::FLAG_3D;
		if (aux_res_s9.north) begin
			flags_d = flags_d | gpsbcd_pkg::FLAG_NORTH;
		end
		if (aux_res_s9.east) begin
			flags_d = flags_d | gpsbcd_pkg::FLAG_EAST;
		end
		if (lon_res_s9.over99) begin
			flags_d = flags_d | gpsbcd_pkg::FLAG_LON_OVER_99;
		end
		if (aux_res_s9.alt_neg) begin
			flags_d = flags_d | gpsbcd_pkg::FLAG_NEG_ALT;
		end
	end

	// output register: digit pairs to bcd
	always_ff @(posedge clk) begin
		if (stage_en[gpsbcd_pkg::NSTAGE]) begin
			alt_bcd_s10  <= {gpsbcd_pkg::bcd2(aux_res_s9.alt_hi),
				gpsbcd_pkg::bcd2(aux_res_s9.alt_lo)};
			lat_bcd_s10  <= {gpsbcd_pkg::bcd2(lat_res_s9.deg_lo),
				gpsbcd_pkg::bcd2(lat_res_s9.minutes),
				gpsbcd_pkg::bcd2(lat_res_s9.frac_hi),
				gpsbcd_pkg::bcd2(lat_res_s9.frac_lo)};
			lon_bcd_s10  <= {gpsbcd_pkg::bcd2(lon_res_s9.deg_lo),
				gpsbcd_pkg::bcd2(lon_res_s9.minutes),
				gpsbcd_pkg::bcd2(lon_res_s9.frac_hi),
				gpsbcd_pkg::bcd2(lon_res_s9.frac_lo)};
			crs_bcd_s10  <= {gpsbcd_pkg::bcd2({1'b0, aux_res_s9.crs_hi}),
				gpsbcd_pkg::bcd2(aux_res_s9.crs_lo)};
			hdop_bcd_s10 <= gpsbcd_pkg::bcd2(aux_res_s9.hdop);
			flags_s10    <= flags_d;
		end
	end

	assign record.valid            = vld_q[gpsbcd_pkg::NSTAGE];
	assign record.altitude_low_bcd = alt_bcd_s10;
	assign record.latitude_bcd     = lat_bcd_s10;
	assign record.longitude_bcd    = lon_bcd_s10;
	assign record.course_bcd       = crs_bcd_s10;
	assign record.hdop_bcd         = hdop_bcd_s10;
	assign record.status_flags     = flags_s10;

endmodule

`default_nettype wire

// ===== sv/gpsbcd_chk.sv =====
// gpsbcd_chk: port-level assertions for the gps location bcd encoder, with bind
`default_nettype none

module gpsbcd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        sol_valid,
	input logic        sol_ready,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic [15:0] rec_altitude,
	input logic [31:0] rec_latitude,
	input logic [31:0] rec_longitude,
	input logic [15:0] rec_course,
	input logic [7:0]  rec_hdop,
	input logic [7:0]  rec_flags
);

	localparam logic [7:0] FIXED_SET = gpsbcd_pkg::FLAG_FIX | gpsbcd_pkg::FLAG_DATA
		| gpsbcd_pkg::FLAG_3D;

	// every record carries fix, data and 3d, and bit 6 stays clear
	a_flags_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> ((rec_flags & FIXED_SET) == FIXED_SET) && !rec_flags[6])
		else $error("record status flags missing fixed bits");

	// an empty output register means the pipeline can take a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_valid |-> sol_ready)
		else $error("solution stalled with empty output register");

	// a stalled record holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid
			&& $stable({rec_altitude, rec_latitude, rec_longitude, rec_course, rec_hdop,
				rec_flags}))
		else $error("stalled record changed");

	// hdop holds two decimal digits (at most 99) and the leading course digit is at most 4
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (rec_hdop[3:0] <= 4'd9) && (rec_hdop[7:4] <= 4'd9)
			&& (rec_course[15:12] <= 4'd4))
		else $error("record digit out of range");

endmodule

bind gps_location_bcd_encoder gpsbcd_chk u_gpsbcd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.sol_valid     (solution.valid),
	.sol_ready     (solution.ready),
	.rec_valid     (record.valid),
	.rec_ready     (record.ready),
	.rec_altitude  (record.altitude_low_bcd),
	.rec_latitude  (record.latitude_bcd),
	.rec_longitude (record.longitude_bcd),
	.rec_course    (record.course_bcd),
	.rec_hdop      (record.hdop_bcd),
	.rec_flags     (record.status_flags)
);

`default_nettype wire
